// ===== sv/jmvt_pkg.sv =====
// Shared types, constants and helpers for the joint matrix vertex transform.
// No dependencies; the palette, column and top-level files import this package.
`default_nettype none

package jmvt_pkg;

   // Palette geometry
   localparam int NUM_JOINTS      = 128;
   localparam int WORDS_PER_JOINT = 12;
   localparam int NUM_COORDS      = 3;
   localparam int TRANS_ROW       = 3;
   localparam int JOINT_AW        = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;

   // Field widths
   localparam int WORD_W      = 32;
   localparam int JOINT_W     = 8;
   localparam int JOINT_CMP_W = JOINT_W + 1;
   localparam int SLOT_W      = 4;
   localparam int PROD_W      = 2 * WORD_W;
   localparam int SUM_W       = PROD_W + 2;
   localparam int FRAC_W      = 16;
   localparam int SHIFT_W     = SUM_W - FRAC_W;
   localparam int ACC_W       = SHIFT_W + 1;

   // Stream word widths
   localparam int REQ_DATA_W = 144;
   localparam int RSP_DATA_W = NUM_COORDS * WORD_W;

   typedef logic signed [WORD_W-1:0] word_type;
   typedef word_type [WORDS_PER_JOINT-1:0] matrix_type;
   typedef word_type [NUM_COORDS-1:0] vec_type;

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_XFORM = 1'b1
   } opcode_type;

   localparam word_type WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
   localparam word_type WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

   // Load enables of the arithmetic stages
   typedef struct packed {
      logic s2;
      logic s3;
   } stage_en_type;

   // True when the signed joint index names a palette matrix
   function automatic logic joint_ok(input logic [JOINT_W-1:0] joint);
      logic [JOINT_CMP_W-1:0] ext;
      ext = {1'b0, joint};
      return !joint[JOINT_W-1] && (ext < JOINT_CMP_W'(NUM_JOINTS));
   endfunction

endpackage

`default_nettype wire

// ===== sv/jmvt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Standalone; used for every palette bank.
`default_nettype none

module jmvt_ram #(
   parameter int  WIDTH = 32,
   parameter int  DEPTH = 128,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port; hold data while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== sv/jmvt_palette.sv =====
// Joint matrix palette: one RAM bank per matrix word so all words of a matrix are read together.
// Depends on jmvt_pkg and jmvt_ram.
`default_nettype none

module jmvt_palette (
   input  wire logic                              clock,
   input  wire logic                              wr_en,
   input  wire logic [jmvt_pkg::JOINT_AW-1:0]     wr_joint,
   input  wire logic [jmvt_pkg::SLOT_W-1:0]       wr_slot,
   input  wire jmvt_pkg::word_type                wr_data,
   input  wire logic                              rd_en,
   input  wire logic [jmvt_pkg::JOINT_AW-1:0]     rd_joint,
   output jmvt_pkg::matrix_type                   rd_matrix
);
   import jmvt_pkg::*;

   // Steer the write to the bank of its slot; read all banks at one joint
   for (genvar s = 0; s < WORDS_PER_JOINT; s++) begin : g_bank
      logic bank_we;
      assign bank_we = wr_en && (wr_slot == SLOT_W'(s));

      jmvt_ram #(
         .WIDTH (WORD_W),
         .DEPTH (NUM_JOINTS)
      ) u_ram (
         .clock   (clock),
         .wr_en   (bank_we),
         .wr_addr (wr_joint),
         .wr_data (wr_data),
         .rd_en   (rd_en),
         .rd_addr (rd_joint),
         .rd_data (rd_matrix[s])
      );
   end

endmodule

`default_nettype wire

// ===== sv/jmvt_column.sv =====
// One output coordinate: three products, exact sum, Q16.16 truncation, translation and saturation.
// Depends on jmvt_pkg; stage enables come from the top-level pipeline control.
`default_nettype none

module jmvt_column (
   input  wire logic                  clock,
   input  wire jmvt_pkg::stage_en_type en,
   input  wire jmvt_pkg::vec_type      m_col,
   input  wire jmvt_pkg::word_type     trans,
   input  wire jmvt_pkg::vec_type      pos,
   output jmvt_pkg::word_type          result,
   output logic                        sat
);
   import jmvt_pkg::*;

   logic signed [PROD_W-1:0]  prod_ff [NUM_COORDS];
   logic signed [PROD_W-1:0]  prod_in [NUM_COORDS];
   word_type                  trans2_ff;
   logic signed [SUM_W-1:0]   sum_full;
   logic signed [SHIFT_W-1:0] sum_ff;
   logic signed [SHIFT_W-1:0] sum_in;
   word_type                  trans3_ff;
   logic signed [ACC_W-1:0]   acc;
   logic                      ovf;

   // Stage 2: one product per matrix row
   always_comb begin
      for (int r = 0; r < NUM_COORDS; r++) begin
         prod_in[r] = PROD_W'(m_col[r]) * PROD_W'(pos[r]);
      end
   end

   always_ff @(posedge clock) begin
      if (en.s2) begin
         for (int r = 0; r < NUM_COORDS; r++) begin
            prod_ff[r] <= prod_in[r];
         end
         trans2_ff <= trans;
      end
   end

   // Stage 3: exact sum, drop fraction bits (floor)
   assign sum_full = SUM_W'(prod_ff[0]) + SUM_W'(prod_ff[1]) + SUM_W'(prod_ff[2]);
   assign sum_in   = sum_full[SUM_W-1:FRAC_W];

   always_ff @(posedge clock) begin
      if (en.s3) begin
         sum_ff    <= sum_in;
         trans3_ff <= trans2_ff;
      end
   end

   // Add translation and clip to 32 bits; registered by the caller
   assign acc    = ACC_W'(sum_ff) + ACC_W'(trans3_ff);
   assign ovf    = (acc[ACC_W-1:WORD_W-1] != {(ACC_W-WORD_W+1){acc[WORD_W-1]}});
   assign sat    = ovf;
   assign result = !ovf ? acc[WORD_W-1:0] : (acc[ACC_W-1] ? WORD_MIN : WORD_MAX);

endmodule

`default_nettype wire

// ===== sv/joint_matrix_vertex_transform.sv =====
// Single-bone matrix palette vertex transform.
// A vertex word passes four register stages on its way to rsp: palette read, multiply, sum, clip.
// Throughput: one word per cycle while rsp_tready does not hold the pipeline; palette writes finish at accept.
// A palette write is seen by a vertex accepted in the next cycle or later; writes give no result.
// Reset clears the stage valid bits only; the palette is not cleared and is undefined until written.
`default_nettype none

module joint_matrix_vertex_transform (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // req_tdata: joint_index[7:0], matrix_slot[11:8], matrix_word[43:12],
   //            pos_x[75:44], pos_y[107:76], pos_z[139:108], zero pad[143:140]
   input  wire logic [jmvt_pkg::REQ_DATA_W-1:0]     req_tdata,
   // req_tuser: opcode[0]
   input  wire logic [0:0]                          req_tuser,
   input  wire logic                                req_tlast,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // rsp_tdata: out_x[31:0], out_y[63:32], out_z[95:64]
   output logic [jmvt_pkg::RSP_DATA_W-1:0]          rsp_tdata,
   // rsp_tuser: saturated[0]
   output logic [0:0]                               rsp_tuser,
   output logic                                     rsp_tlast,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready
);
   import jmvt_pkg::*;

   // Request word fields
   logic [JOINT_W-1:0] req_joint;
   logic [SLOT_W-1:0]  req_slot;
   word_type           req_word;
   vec_type            req_pos;
   opcode_type         req_op;
   logic               req_fire;
   logic               wr_go;

   assign req_joint  = req_tdata[7:0];
   assign req_slot   = req_tdata[11:8];
   assign req_word   = req_tdata[43:12];
   assign req_pos[0] = req_tdata[75:44];
   assign req_pos[1] = req_tdata[107:76];
   assign req_pos[2] = req_tdata[139:108];
   assign req_op     = opcode_type'(req_tuser[0]);

   // Pipeline control: a stage loads when it is empty or its contents move on
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic v1_in, v2_in, v3_in, v4_in;
   logic adv1, adv2, adv3, adv4;
   stage_en_type col_en;

   assign adv4       = !v4_ff || rsp_tready;
   assign adv3       = !v3_ff || adv4;
   assign adv2       = !v2_ff || adv3;
   assign adv1       = !v1_ff || adv2;
   assign req_tready = adv1;
   assign req_fire   = req_tvalid && adv1;
   assign col_en.s2  = adv2;
   assign col_en.s3  = adv3;

   assign v1_in = adv1 ? (req_fire && (req_op == OP_XFORM)) : v1_ff;
   assign v2_in = adv2 ? v1_ff : v2_ff;
   assign v3_in = adv3 ? v2_ff : v3_ff;
   assign v4_in = adv4 ? v3_ff : v4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   // Palette: write at accept, read the whole matrix into stage 1
   matrix_type rd_matrix;

   assign wr_go = req_fire && (req_op == OP_WRITE) && joint_ok(req_joint)
                  && (req_slot < SLOT_W'(WORDS_PER_JOINT));

   jmvt_palette u_palette (
      .clock     (clock),
      .wr_en     (wr_go),
      .wr_joint  (req_joint[JOINT_AW-1:0]),
      .wr_slot   (req_slot),
      .wr_data   (req_word),
      .rd_en     (adv1),
      .rd_joint  (req_joint[JOINT_AW-1:0]),
      .rd_matrix (rd_matrix)
   );

   // Side data carried alongside the arithmetic
   vec_type pos1_ff, pos2_ff, pos3_ff;
   logic    pass1_ff, pass2_ff, pass3_ff, pass4_ff;
   logic    last1_ff, last2_ff, last3_ff, last4_ff;

   always_ff @(posedge clock) begin
      if (adv1) begin
         pos1_ff  <= req_pos;
         pass1_ff <= !joint_ok(req_joint);
         last1_ff <= req_tlast;
      end
      if (adv2) begin
         pos2_ff  <= pos1_ff;
         pass2_ff <= pass1_ff;
         last2_ff <= last1_ff;
      end
      if (adv3) begin
         pos3_ff  <= pos2_ff;
         pass3_ff <= pass2_ff;
         last3_ff <= last2_ff;
      end
   end

   // Three column datapaths
   vec_type                 col_res;
   logic [NUM_COORDS-1:0]   col_sat;

   for (genvar c = 0; c < NUM_COORDS; c++) begin : g_col
      vec_type m_col;
      assign m_col[0] = rd_matrix[c];
      assign m_col[1] = rd_matrix[NUM_COORDS + c];
      assign m_col[2] = rd_matrix[2 * NUM_COORDS + c];

      jmvt_column u_column (
         .clock  (clock),
         .en     (col_en),
         .m_col  (m_col),
         .trans  (rd_matrix[TRANS_ROW * NUM_COORDS + c]),
         .pos    (pos1_ff),
         .result (col_res[c]),
         .sat    (col_sat[c])
      );
   end

   // Stage 4: output register, pass the vertex through when there is no bone
   vec_type out_ff, out_in;
   logic    sat4_ff, sat4_in;

   assign out_in  = pass3_ff ? pos3_ff : col_res;
   assign sat4_in = !pass3_ff && (|col_sat);

   always_ff @(posedge clock) begin
      if (adv4) begin
         out_ff   <= out_in;
         sat4_ff  <= sat4_in;
         last4_ff <= last3_ff;
         pass4_ff <= pass3_ff;
      end
   end

   assign rsp_tdata  = out_ff;
   assign rsp_tuser  = sat4_ff;
   assign rsp_tlast  = last4_ff;
   assign rsp_tvalid = v4_ff;

   // A pass-through word never reports clipping
   a_pass_no_sat: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && pass4_ff) |-> !rsp_tuser[0])
      else $error("pass-through word flagged as saturated");

   // A clipped word holds a full-scale coordinate
   a_sat_full_scale: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |->
         (out_ff[0] == WORD_MAX || out_ff[0] == WORD_MIN ||
          out_ff[1] == WORD_MAX || out_ff[1] == WORD_MIN ||
          out_ff[2] == WORD_MAX || out_ff[2] == WORD_MIN))
      else $error("saturation flag without a clipped coordinate");

   // A palette write leaves no word in the pipeline
   a_write_no_word: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && opcode_type'(req_tuser[0]) == OP_WRITE) |=> !v1_ff)
      else $error("palette write entered the pipeline");

   // An accepted vertex always occupies stage 1
   a_xform_enters: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && opcode_type'(req_tuser[0]) == OP_XFORM) |=> v1_ff)
      else $error("accepted vertex lost at stage 1");

endmodule

`default_nettype wire

// ===== tb/sv/jmvt_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the joint matrix vertex transform: mirrors the joint palette,
// predicts every skinned vertex and compares it with the rsp stream. Needs jmvt_pkg.

module jmvt_checker (
   input  logic                          clock,
   input  logic                          reset,
   // req_tdata: joint_index, matrix_slot, matrix_word, pos_x, pos_y, pos_z, pad
   input  logic [jmvt_pkg::REQ_DATA_W-1:0] req_tdata,
   // req_tuser: opcode
   input  logic [0:0]                    req_tuser,
   input  logic                          req_tlast,
   input  logic                          req_tvalid,
   input  logic                          req_tready,
   // rsp_tdata: out_x, out_y, out_z
   input  logic [jmvt_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // rsp_tuser: saturated
   input  logic [0:0]                    rsp_tuser,
   input  logic                          rsp_tlast,
   input  logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output int                            error_count,
   output int                            vertices_pending
);
   import jmvt_pkg::*;

   typedef struct packed {
      vec_type coords;
      logic    clipped;
      logic    mesh_end;
   } vertex_type;

   word_type   palette [NUM_JOINTS][WORDS_PER_JOINT];
   vertex_type skinned_q [$];

   // Exact sum of the three products plus the translation, floored to Q16.16,
   // then clipped to 32 bits
   function automatic vertex_type skin_vertex(input logic signed [JOINT_W-1:0] joint,
                                              input vec_type pos, input logic mesh_end);
      vertex_type        v;
      logic signed [67:0] acc;
      logic signed [67:0] trans;
      logic signed [63:0] prod;
      word_type          m;
      word_type          p;
      v.coords   = pos;
      v.clipped  = 1'b0;
      v.mesh_end = mesh_end;
      if (joint >= 0 && joint < NUM_JOINTS) begin
         for (int c = 0; c < NUM_COORDS; c++) begin
            trans = palette[joint][TRANS_ROW * NUM_COORDS + c];
            acc   = trans <<< FRAC_W;
            for (int r = 0; r < TRANS_ROW; r++) begin
               m    = palette[joint][r * NUM_COORDS + c];
               p    = pos[r];
               prod = m * p;
               acc  = acc + prod;
            end
            acc = acc >>> FRAC_W;
            if (acc > WORD_MAX) begin
               v.coords[c] = WORD_MAX;
               v.clipped   = 1'b1;
            end else if (acc < WORD_MIN) begin
               v.coords[c] = WORD_MIN;
               v.clipped   = 1'b1;
            end else begin
               v.coords[c] = acc[WORD_W-1:0];
            end
         end
      end
      return v;
   endfunction

   function automatic int field_differs(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected %h actual %h", $time, name, want, got);
         return 1;
      end
      return 0;
   endfunction

   // Retire result words first, then take in the request word of this edge
   always @(posedge clock) begin : watch
      vertex_type                 expected;
      vertex_type                 actual;
      logic signed [JOINT_W-1:0]  joint;
      logic [SLOT_W-1:0]          slot;
      int                         errs;
      errs = 0;
      if (reset) begin
         skinned_q.delete();
         error_count <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            actual.coords   = rsp_tdata;
            actual.clipped  = rsp_tuser[0];
            actual.mesh_end = rsp_tlast;
            if (skinned_q.size() == 0) begin
               $display("%0t ns: unexpected result word, expected none actual %h %b %b",
                        $time, rsp_tdata, rsp_tuser, rsp_tlast);
               errs = 1;
            end else begin
               expected = skinned_q.pop_front();
               errs += field_differs("out_x", expected.coords[0], actual.coords[0]);
               errs += field_differs("out_y", expected.coords[1], actual.coords[1]);
               errs += field_differs("out_z", expected.coords[2], actual.coords[2]);
               errs += field_differs("saturated", expected.clipped, actual.clipped);
               errs += field_differs("mesh_done", expected.mesh_end, actual.mesh_end);
            end
         end
         if (req_tvalid && req_tready) begin
            joint = req_tdata[7:0];
            slot  = req_tdata[11:8];
            if (opcode_type'(req_tuser[0]) == OP_XFORM) begin
               skinned_q.push_back(skin_vertex(joint, req_tdata[139:44], req_tlast));
            end else if (joint >= 0 && joint < NUM_JOINTS && slot < WORDS_PER_JOINT) begin
               palette[joint][slot] = req_tdata[43:12];
            end
         end
         if (errs != 0) begin
            error_count <= error_count + errs;
         end
      end
      vertices_pending <= skinned_q.size();
   end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// Top of the vertex transform testbench: clock, reset, both word streams and the verdict.
// Needs jmvt_pkg, jmvt_checker and joint_matrix_vertex_transform.

module testbench;
   import jmvt_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_WORDS = 500;
   localparam int DRAIN_CYCLES = 12;

   logic                  clock;
   logic                  reset;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [0:0]            req_tuser;
   logic                  req_tlast;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [0:0]            rsp_tuser;
   logic                  rsp_tlast;
   logic                  rsp_tvalid;
   logic                  rsp_tready;

   int error_count;
   int vertices_pending;
   int cycle_count = 0;

   // Palette words written so far; only fully loaded joints are transformed
   logic [WORDS_PER_JOINT-1:0] loaded_slots [NUM_JOINTS];
   int                         loaded_joints [$];
   logic                       no_idle = 1'b0;

   joint_matrix_vertex_transform i_dut (.*);
   jmvt_checker i_checker (.*);

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // Random back pressure on the result side, with long ready stretches
   initial begin : rsp_stall
      int pick;
      int len;
      rsp_tready = 1'b0;
      forever begin
         pick = $urandom_range(0, 99);
         @(negedge clock);
         if (pick < 12) begin
            rsp_tready <= 1'b0;
            len = ($urandom_range(0, 5) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
         end else begin
            rsp_tready <= 1'b1;
            len = (pick < 16) ? $urandom_range(100, 300) : $urandom_range(1, 16);
         end
         repeat (len - 1) @(negedge clock);
      end
   end

   function automatic int idle_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (no_idle || pick < 65) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      if (pick < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic word_type extreme_word();
      case ($urandom_range(0, 4))
         0: return WORD_MAX;
         1: return WORD_MIN;
         2: return '0;
         3: return '1;
         default: return 32'h0001_0000;
      endcase
   endfunction

   // Mostly modest coordinates, some full range, a few extremes
   function automatic vec_type random_position();
      vec_type pos;
      int      pick;
      for (int c = 0; c < NUM_COORDS; c++) begin
         pick = $urandom_range(0, 9);
         if (pick < 6) pos[c] = $urandom_range(0, 1 << 22) - (1 << 21);
         else if (pick < 9) pos[c] = $urandom;
         else pos[c] = extreme_word();
      end
      return pos;
   endfunction

   // Style 0 near rigid, 1 small, 2 full range, 3 extremes
   function automatic word_type matrix_value(input int style, input int slot);
      case (style)
         0: begin
            if (slot >= TRANS_ROW * NUM_COORDS) return $urandom_range(0, 1 << 23) - (1 << 22);
            if (slot % 4 == 0) return 32'h0001_0000 + $urandom_range(0, 1 << 12) - (1 << 11);
            return $urandom_range(0, 1 << 15) - (1 << 14);
         end
         1: return $urandom_range(0, 1 << 18) - (1 << 17);
         2: return $urandom;
         default: return extreme_word();
      endcase
   endfunction

   // Drive one request word at the falling edge and hold it until accepted
   task automatic push_word(input opcode_type op, input logic signed [JOINT_W-1:0] joint,
                            input logic [SLOT_W-1:0] slot, input word_type value,
                            input vec_type pos, input logic last);
      int gap;
      gap = idle_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, pos, value, slot, joint};
      req_tuser  <= op;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic write_word(input logic signed [JOINT_W-1:0] joint,
                             input logic [SLOT_W-1:0] slot, input word_type value,
                             input logic last);
      logic was_full;
      if (joint >= 0 && joint < NUM_JOINTS && slot < WORDS_PER_JOINT) begin
         was_full = &loaded_slots[joint];
         loaded_slots[joint][slot] = 1'b1;
         if (!was_full && &loaded_slots[joint]) loaded_joints.push_back(joint);
      end
      push_word(OP_WRITE, joint, slot, value, random_position(), last);
   endtask

   task automatic transform(input logic signed [JOINT_W-1:0] joint, input vec_type pos,
                            input logic last);
      push_word(OP_XFORM, joint, $urandom_range(0, 15), $urandom, pos, last);
   endtask

   initial begin : stimulus
      logic signed [JOINT_W-1:0] joint;
      int                        counted;
      int                        pick;
      int                        style;
      int                        batch;
      int                        slot;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      req_tlast  = 1'b0;
      counted    = 0;
      for (int j = 0; j < NUM_JOINTS; j++) loaded_slots[j] = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Pass through on no bone and on bad joints
      transform(-1, {WORD_MIN, WORD_MAX, word_type'(0)}, 1'b0);
      transform(-128, {WORD_MIN, word_type'(-1), WORD_MAX}, 1'b1);
      transform(-2, random_position(), 1'b0);
      // Ignored writes: negative joint, slot past the matrix
      write_word(-5, 3, WORD_MAX, 1'b1);
      write_word(0, 15, WORD_MIN, 1'b0);
      // Last joint loaded with extremes, then driven into saturation both ways
      for (int s = 0; s < WORDS_PER_JOINT; s++) begin
         if (s < TRANS_ROW * NUM_COORDS) write_word(NUM_JOINTS - 1, s,
                                                    (s % 2) ? WORD_MIN : WORD_MAX, 1'b0);
         else if (s == 9) write_word(NUM_JOINTS - 1, s, WORD_MAX, 1'b0);
         else if (s == 10) write_word(NUM_JOINTS - 1, s, WORD_MIN, 1'b0);
         else write_word(NUM_JOINTS - 1, s, '0, 1'b1);
      end
      transform(NUM_JOINTS - 1, {WORD_MAX, WORD_MAX, WORD_MAX}, 1'b0);
      transform(NUM_JOINTS - 1, '0, 1'b0);
      transform(NUM_JOINTS - 1, {WORD_MIN, WORD_MIN, WORD_MIN}, 1'b1);

      // Random part: load matrices, stream meshes, overwrite words, some noise
      while (counted < RANDOM_WORDS) begin
         pick    = $urandom_range(0, 99);
         no_idle = ($urandom_range(0, 5) == 0);
         if (pick < 15 || loaded_joints.size() == 0) begin
            joint = $urandom_range(0, NUM_JOINTS - 1);
            style = $urandom_range(0, 3);
            for (int s = 0; s < WORDS_PER_JOINT; s++) begin
               write_word(joint, s, matrix_value(style, s), $urandom_range(0, 1));
            end
            counted += WORDS_PER_JOINT;
         end else if (pick < 85) begin
            batch = $urandom_range(1, 24);
            for (int v = 0; v < batch; v++) begin
               if ($urandom_range(0, 9) == 0) joint = -1;
               else joint = loaded_joints[$urandom_range(0, loaded_joints.size() - 1)];
               transform(joint, random_position(), v == batch - 1);
            end
            counted += batch;
         end else if (pick < 92) begin
            joint = loaded_joints[$urandom_range(0, loaded_joints.size() - 1)];
            slot  = $urandom_range(0, WORDS_PER_JOINT - 1);
            write_word(joint, slot, matrix_value($urandom_range(0, 3), slot),
                       $urandom_range(0, 1));
            counted++;
         end else begin
            case ($urandom_range(0, 2))
               0: write_word(-$urandom_range(1, 128), $urandom_range(0, 15), $urandom,
                             $urandom_range(0, 1));
               1: write_word($urandom_range(0, NUM_JOINTS - 1), $urandom_range(12, 15),
                             $urandom, $urandom_range(0, 1));
               default: begin
                  transform(-$urandom_range(2, 128), random_position(), $urandom_range(0, 1));
                  counted++;
               end
            endcase
         end
      end
      @(negedge clock);
      req_tvalid <= 1'b0;

      // Drain, then allow for the pipeline depth
      while (vertices_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && vertices_pending == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/jmvt_pkg.sv
sv/jmvt_ram.sv
sv/jmvt_palette.sv
sv/jmvt_column.sv
sv/joint_matrix_vertex_transform.sv
tb/sv/jmvt_checker.sv
tb/sv/testbench.sv
